// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the keyboard decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PS2D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PS2D_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PS2D_ASSERT(lbl, prop, msg)
`define PS2D_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/core/ps2d_pkg.sv
// ---------------------------------------------------------------------------
// ps2d_pkg
// Types, codes and sizes for the set-1 scancode decoder.
// ---------------------------------------------------------------------------
package ps2d_pkg;

	localparam int LAYOUT_COUNT  = 4;
	localparam int KEYCODE_COUNT = 128;
	localparam int MOD_COUNT     = 3;
	localparam int TABLE_DEPTH   = LAYOUT_COUNT * MOD_COUNT * KEYCODE_COUNT;
	localparam int KEY_W         = $clog2(KEYCODE_COUNT);
	localparam int ROW_W         = $clog2(LAYOUT_COUNT * MOD_COUNT);
	localparam int ADDR_W        = ROW_W + KEY_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// operation codes
	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_POLL  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// keymap modifier rows
	localparam logic [1:0] ROW_PLAIN   = 2'd0;
	localparam logic [1:0] ROW_SHIFTED = 2'd1;
	localparam logic [1:0] ROW_ALTGR   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_UP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_DOWN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEFT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_RIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_HOME  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_BASE  = 3'd6;

	// scancode bytes
	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [6:0] KEY_CTRL      = 7'h1D;
	localparam logic [6:0] KEY_ALT       = 7'h38;
	localparam logic [6:0] KEY_LSHIFT    = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT    = 7'h36;
	localparam logic [6:0] KEY_CAPS      = 7'h3A;
	localparam logic [6:0] KEY_NAV_UP    = 7'h48;
	localparam logic [6:0] KEY_NAV_DOWN  = 7'h50;
	localparam logic [6:0] KEY_NAV_LEFT  = 7'h4B;
	localparam logic [6:0] KEY_NAV_RIGHT = 7'h4D;
	localparam logic [6:0] KEY_NAV_HOME  = 7'h47;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	typedef struct packed {
		logic caps;
		logic altgr;
		logic alt;
		logic ctrl;
		logic shift;
	} mod_flags_t;

	typedef struct packed {
		logic       lookup;
		logic       ctrl_apply;
		logic [7:0] direct_char;
		mod_flags_t flags;
	} stage_t;

endpackage

// File: rtl/core/ps2d_cmd_if.sv
// ---------------------------------------------------------------------------
// ps2d_cmd_if
// Input item channel: scancode, poll or keymap write.
// ---------------------------------------------------------------------------
interface ps2d_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] scancode;
	logic [1:0] table_layout;
	logic [1:0] table_modifier;
	logic [6:0] table_keycode;
	logic [7:0] table_char;

	modport source (
		output valid, operation, scancode, table_layout, table_modifier,
			table_keycode, table_char,
		input  ready
	);
	modport sink (
		input  valid, operation, scancode, table_layout, table_modifier,
			table_keycode, table_char,
		output ready
	);
endinterface

// File: rtl/core/ps2d_res_if.sv
// ---------------------------------------------------------------------------
// ps2d_res_if
// Result item channel: decoded character and modifier flags.
// ---------------------------------------------------------------------------
interface ps2d_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       shift_held;
	logic       ctrl_held;
	logic       alt_held;
	logic       altgr_held;
	logic       caps_active;

	modport source (
		output valid, char_out, shift_held, ctrl_held, alt_held, altgr_held,
			caps_active,
		input  ready
	);
	modport sink (
		input  valid, char_out, shift_held, ctrl_held, alt_held, altgr_held,
			caps_active,
		output ready
	);
endinterface

// File: rtl/core/ps2_scancode_to_char_decoder_top.sv
// ---------------------------------------------------------------------------
// ps2_scancode_to_char_decoder_top
// Set-1 scancode decoder with prefix and modifier tracking and a loadable
// keymap RAM (layout x modifier x keycode).
// ---------------------------------------------------------------------------
//  channel | dir | handshake        | content
//  cmd     | in  | valid/ready      | operation, scancode, keymap entry
//  res     | out | valid/ready      | char_out and five modifier flags
//  cfg     | in  | cfg_we, no ready | cfg_index, cfg_wdata
//
//  One item per cycle sustained while results are taken; a result passes
//  through the keymap RAM read register (with the lookup stage) and then
//  the output register. Prefix and modifier flags update at acceptance.
//  Reset clears flags and loads the register defaults; the keymap is
//  undefined until written.
//  A stalled result holds the lookup stage, which holds cmd.ready low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2_scancode_to_char_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ps2d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ps2d_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ps2d_cmd_if.sink                          cmd,
	ps2d_res_if.source                        res
);
	import ps2d_pkg::*;

	logic [1:0] layout_q;
	logic [7:0] code_up_q, code_down_q, code_left_q, code_right_q, code_home_q;
	logic [7:0] ctrl_base_q;

	logic       prefix_q, prefix_d;
	mod_flags_t flags_q, flags_d;

	stage_t     stage_d, stage_s1;
	logic       valid_s1;
	logic       res_valid_q;
	logic [7:0] char_q;
	mod_flags_t res_flags_q;

	logic       accept, advance;
	logic       lookup;
	logic [7:0] direct_char;
	logic [1:0] mod_sel;
	logic       layout_ok, entry_ok;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        rd_data_q;
	logic [7:0]        key_mem [TABLE_DEPTH];

	logic [6:0] key;
	logic       rel;
	logic [7:0] char_sel, char_fin;

	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;

	assign key = cmd.scancode[6:0];
	assign rel = cmd.scancode[7];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q     <= 2'd0;
			code_up_q    <= 8'd128;
			code_down_q  <= 8'd129;
			code_left_q  <= 8'd130;
			code_right_q <= 8'd131;
			code_home_q  <= 8'd132;
			ctrl_base_q  <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAYOUT:     layout_q     <= cfg_wdata[1:0];
				CFG_CODE_UP:    code_up_q    <= cfg_wdata;
				CFG_CODE_DOWN:  code_down_q  <= cfg_wdata;
				CFG_CODE_LEFT:  code_left_q  <= cfg_wdata;
				CFG_CODE_RIGHT: code_right_q <= cfg_wdata;
				CFG_CODE_HOME:  code_home_q  <= cfg_wdata;
				CFG_CTRL_BASE:  ctrl_base_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// decode
	always_comb begin
		prefix_d    = prefix_q;
		flags_d     = flags_q;
		lookup      = 1'b0;
		direct_char = 8'd0;
		unique case (cmd.operation)
			OP_SCAN: begin
				if (cmd.scancode == SC_PREFIX) begin
					prefix_d = 1'b1;
				end else if (prefix_q) begin
					prefix_d = 1'b0;
					if (rel) begin
						if (key == KEY_CTRL)
							flags_d.ctrl = 1'b0;
						else if (key == KEY_ALT)
							flags_d.altgr = 1'b0;
					end else begin
						unique case (key)
							KEY_NAV_UP:    direct_char = code_up_q;
							KEY_NAV_DOWN:  direct_char = code_down_q;
							KEY_NAV_LEFT:  direct_char = code_left_q;
							KEY_NAV_RIGHT: direct_char = code_right_q;
							KEY_NAV_HOME:  direct_char = code_home_q;
							KEY_CTRL:      flags_d.ctrl = 1'b1;
							KEY_ALT:       flags_d.altgr = 1'b1;
							default: ;
						endcase
					end
				end else begin
					unique case (key) inside
						KEY_LSHIFT, KEY_RSHIFT: flags_d.shift = !rel;
						KEY_CAPS: if (!rel) flags_d.caps = !flags_q.caps;
						KEY_CTRL: flags_d.ctrl = !rel;
						KEY_ALT:  flags_d.alt = !rel;
						default:  lookup = !rel;
					endcase
				end
			end
			OP_POLL: prefix_d = 1'b0;
			default: ;
		endcase
	end

	assign layout_ok = 32'(layout_q) < LAYOUT_COUNT;
	assign entry_ok  = (32'(cmd.table_layout) < LAYOUT_COUNT)
		&& (32'(cmd.table_modifier) < MOD_COUNT);

	always_comb begin
		if (flags_q.altgr)
			mod_sel = ROW_ALTGR;
		else if (flags_q.shift ^ flags_q.caps)
			mod_sel = ROW_SHIFTED;
		else
			mod_sel = ROW_PLAIN;
	end

	assign ram_re    = accept && lookup && layout_ok;
	assign ram_we    = accept && (cmd.operation == OP_WRITE) && entry_ok;
	assign ram_raddr = {ROW_W'(ROW_W'(layout_q) * ROW_W'(MOD_COUNT) + ROW_W'(mod_sel)), key};
	assign ram_waddr = {ROW_W'(ROW_W'(cmd.table_layout) * ROW_W'(MOD_COUNT)
		+ ROW_W'(cmd.table_modifier)), cmd.table_keycode};

	always_ff @(posedge clk) begin
		if (ram_we)
			key_mem[ram_waddr] <= cmd.table_char;
		if (ram_re)
			rd_data_q <= key_mem[ram_raddr];
	end

	always_comb begin
		stage_d.lookup      = lookup && layout_ok;
		stage_d.ctrl_apply  = flags_q.ctrl && !flags_q.altgr;
		stage_d.direct_char = direct_char;
		stage_d.flags       = flags_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			flags_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				prefix_q <= prefix_d;
				flags_q  <= flags_d;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			stage_s1 <= stage_d;
	end

	// ctrl remap of looked-up characters in the range A to z
	always_comb begin
		char_sel = stage_s1.lookup ? rd_data_q : stage_s1.direct_char;
		char_fin = char_sel;
		if (stage_s1.lookup && stage_s1.ctrl_apply
			&& char_sel >= CHAR_UPPER_A && char_sel <= CHAR_LOWER_Z)
			char_fin = char_sel - CHAR_UPPER_A + ctrl_base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			char_q      <= char_fin;
			res_flags_q <= stage_s1.flags;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.char_out    = char_q;
	assign res.shift_held  = res_flags_q.shift;
	assign res.ctrl_held   = res_flags_q.ctrl;
	assign res.alt_held    = res_flags_q.alt;
	assign res.altgr_held  = res_flags_q.altgr;
	assign res.caps_active = res_flags_q.caps;

	`PS2D_NEVER(a_rd_wr_same_cycle, ram_re && ram_we, "keymap read and write in one cycle")
	`PS2D_ASSERT(a_stall_blocks_cmd, valid_s1 && !advance |-> !cmd.ready, "cmd taken while stalled")
	`PS2D_ASSERT(a_stage_held, valid_s1 && !advance |=> valid_s1, "lookup stage dropped")
	`PS2D_ASSERT(a_stage_to_res, valid_s1 && advance |=> res_valid_q, "result lost at output")

endmodule

// File: verif/ps2d_checker.sv
// ----------------------------------------------------------------------------
// ps2d_checker
// Watches the command, result and configuration ports of the scancode decoder.
// It keeps its own copy of the prefix flag, the modifier flags, the keymap and
// the registers. It predicts the character and flags for every accepted
// command item and compares each accepted result item, in order, against the
// prediction.
// ----------------------------------------------------------------------------
module ps2d_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ps2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ps2d_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ps2d_cmd_if                             cmd,
	ps2d_res_if                             res,
	output int                              failures,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ps2d_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		mod_flags_t flags;
	} decoded_t;

	logic [1:0] layout;
	logic [7:0] code_up, code_down, code_left, code_right, code_home, ctrl_base;
	logic       prefix;
	mod_flags_t flags;
	logic [7:0] key_map [TABLE_DEPTH];
	decoded_t   char_queue [$];
	decoded_t   want;

	function automatic decoded_t decode_item(input logic [1:0] op, input logic [7:0] sc,
			input logic [1:0] lay, input logic [1:0] m, input logic [6:0] key,
			input logic [7:0] ch);
		decoded_t   d;
		logic [6:0] k;
		logic       rel;
		logic [1:0] mrow;
		d.ch = '0;
		k = sc[6:0];
		rel = sc[7];
		if (op == OP_SCAN) begin
			if (sc == SC_PREFIX) begin
				prefix = 1'b1;
			end else if (prefix) begin
				prefix = 1'b0;
				if (rel) begin
					if (k == KEY_CTRL)
						flags.ctrl = 1'b0;
					else if (k == KEY_ALT)
						flags.altgr = 1'b0;
				end else begin
					case (k)
						KEY_NAV_UP:    d.ch = code_up;
						KEY_NAV_DOWN:  d.ch = code_down;
						KEY_NAV_LEFT:  d.ch = code_left;
						KEY_NAV_RIGHT: d.ch = code_right;
						KEY_NAV_HOME:  d.ch = code_home;
						KEY_CTRL:      flags.ctrl = 1'b1;
						KEY_ALT:       flags.altgr = 1'b1;
						default: ;
					endcase
				end
			end else if (k == KEY_LSHIFT || k == KEY_RSHIFT) begin
				flags.shift = !rel;
			end else if (k == KEY_CAPS) begin
				if (!rel)
					flags.caps = !flags.caps;
			end else if (k == KEY_CTRL) begin
				flags.ctrl = !rel;
			end else if (k == KEY_ALT) begin
				flags.alt = !rel;
			end else if (!rel) begin
				if (flags.altgr)
					mrow = ROW_ALTGR;
				else if (flags.shift != flags.caps)
					mrow = ROW_SHIFTED;
				else
					mrow = ROW_PLAIN;
				if (int'(layout) < LAYOUT_COUNT)
					d.ch = key_map[(int'(layout) * MOD_COUNT + int'(mrow)) * KEYCODE_COUNT
						+ int'(k)];
				if (flags.ctrl && !flags.altgr && d.ch >= CHAR_UPPER_A && d.ch <= CHAR_LOWER_Z)
					d.ch = d.ch - CHAR_UPPER_A + ctrl_base;
			end
		end else if (op == OP_POLL) begin
			prefix = 1'b0;
		end else if (op == OP_WRITE) begin
			if (int'(lay) < LAYOUT_COUNT && int'(m) < MOD_COUNT)
				key_map[(int'(lay) * MOD_COUNT + int'(m)) * KEYCODE_COUNT + int'(key)] = ch;
		end
		d.flags = flags;
		return d;
	endfunction

	function automatic void check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout = '0;
			code_up = 8'd128;
			code_down = 8'd129;
			code_left = 8'd130;
			code_right = 8'd131;
			code_home = 8'd132;
			ctrl_base = 8'd1;
			prefix = 1'b0;
			flags = '0;
			failures = 0;
			char_queue.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LAYOUT:     layout = cfg_wdata[1:0];
					CFG_CODE_UP:    code_up = cfg_wdata;
					CFG_CODE_DOWN:  code_down = cfg_wdata;
					CFG_CODE_LEFT:  code_left = cfg_wdata;
					CFG_CODE_RIGHT: code_right = cfg_wdata;
					CFG_CODE_HOME:  code_home = cfg_wdata;
					CFG_CTRL_BASE:  ctrl_base = cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				char_queue.push_back(decode_item(cmd.operation, cmd.scancode, cmd.table_layout,
					cmd.table_modifier, cmd.table_keycode, cmd.table_char));
			if (res.valid && res.ready) begin
				if (char_queue.size() == 0) begin
					$error("res: item with no expected result");
					failures++;
				end else begin
					want = char_queue.pop_front();
					check_field("char_out", want.ch, res.char_out);
					check_field("shift_held", want.flags.shift, res.shift_held);
					check_field("ctrl_held", want.flags.ctrl, res.ctrl_held);
					check_field("alt_held", want.flags.alt, res.alt_held);
					check_field("altgr_held", want.flags.altgr, res.altgr_held);
					check_field("caps_active", want.flags.caps, res.caps_active);
				end
			end
			pending <= char_queue.size();
		end
	end
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the set-1 scancode decoder. A directed pass covers modifiers,
// caps lock, ctrl mapping, extended keys, polls and keymap writes. Random
// phases follow, each under its own register setting. Keymap entries are
// filled before any key press can read them. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
	import ps2d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] MOD_INVALID = 2'd3;
	localparam logic [6:0] KEY_Q       = 7'h10;
	localparam int         ITEM_TARGET = 1900;
	localparam int         PHASES      = 5;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    failures;
	int                    pending;
	int                    items_sent;
	int                    max_gap;
	logic [1:0]            cur_layout;
	bit                    written [LAYOUT_COUNT][MOD_COUNT][KEYCODE_COUNT];

	ps2d_cmd_if cmd_ch ();
	ps2d_res_if res_ch ();

	ps2_scancode_to_char_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	ps2d_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 5))
			0: return CHAR_UPPER_A;
			1: return CHAR_LOWER_Z;
			2: return CHAR_UPPER_A - 8'd1;
			3: return CHAR_LOWER_Z + 8'd1;
			4: return 8'($urandom_range(CHAR_UPPER_A, CHAR_LOWER_Z));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [7:0] sc, input logic [1:0] lay,
			input logic [1:0] m, input logic [6:0] key, input logic [7:0] ch);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.scancode <= sc;
		cmd_ch.table_layout <= lay;
		cmd_ch.table_modifier <= m;
		cmd_ch.table_keycode <= key;
		cmd_ch.table_char <= ch;
		do @(posedge clk); while (!cmd_ch.ready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_write(input logic [1:0] lay, input logic [1:0] m, input logic [6:0] key,
			input logic [7:0] ch);
		send_item(OP_WRITE, 8'($urandom), lay, m, key, ch);
		if (int'(m) < MOD_COUNT)
			written[lay][m][key] = 1'b1;
	endtask

	task automatic send_poll();
		send_item(OP_POLL, 8'($urandom), 2'($urandom), 2'($urandom), 7'($urandom), 8'($urandom));
	endtask

	// fill the keymap rows a plain press could read before sending it
	task automatic send_scan(input logic [7:0] sc);
		logic [6:0] k;
		k = sc[6:0];
		if (sc != SC_PREFIX && !sc[7] && k != KEY_LSHIFT && k != KEY_RSHIFT && k != KEY_CAPS
				&& k != KEY_CTRL && k != KEY_ALT) begin
			for (int m = 0; m < MOD_COUNT; m++)
				if (!written[cur_layout][m][k])
					send_write(cur_layout, 2'(m), k, pick_char());
		end
		send_item(OP_SCAN, sc, 2'($urandom), 2'($urandom), 7'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] lay, input logic [7:0] up,
			input logic [7:0] down, input logic [7:0] left, input logic [7:0] right,
			input logic [7:0] home, input logic [7:0] base);
		logic [7:0] vals [CFG_CTRL_BASE+1];
		vals[CFG_LAYOUT] = lay;
		vals[CFG_CODE_UP] = up;
		vals[CFG_CODE_DOWN] = down;
		vals[CFG_CODE_LEFT] = left;
		vals[CFG_CODE_RIGHT] = right;
		vals[CFG_CODE_HOME] = home;
		vals[CFG_CTRL_BASE] = base;
		for (int i = CFG_LAYOUT; i <= CFG_CTRL_BASE; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_layout = lay[1:0];
	endtask

	task automatic run_directed();
		logic [6:0] nav [5];
		nav = '{KEY_NAV_UP, KEY_NAV_DOWN, KEY_NAV_LEFT, KEY_NAV_RIGHT, KEY_NAV_HOME};
		send_poll();
		send_item(OP_UNUSED, 8'hFF, 2'd3, 2'd3, 7'h7F, 8'hFF);
		send_write(2'd0, ROW_PLAIN, KEY_Q, CHAR_LOWER_Z);
		send_write(2'd0, ROW_SHIFTED, KEY_Q, CHAR_UPPER_A);
		send_write(2'd0, ROW_ALTGR, KEY_Q, 8'h7B);
		send_write(2'd3, MOD_INVALID, KEY_Q, 8'hFF);
		send_write(2'd3, ROW_PLAIN, 7'h7F, 8'hFF);
		send_scan({1'b0, KEY_Q});
		send_scan({1'b0, KEY_LSHIFT});
		send_scan({1'b0, KEY_Q});
		send_scan({1'b0, KEY_CAPS});
		send_scan({1'b0, KEY_Q});
		send_scan({1'b1, KEY_LSHIFT});
		send_scan({1'b1, KEY_CAPS});
		send_scan({1'b0, KEY_CTRL});
		send_scan({1'b0, KEY_Q});
		send_scan({1'b1, KEY_CTRL});
		send_scan(SC_PREFIX);
		foreach (nav[i]) begin
			send_scan(SC_PREFIX);
			send_scan({1'b0, nav[i]});
		end
		send_scan(SC_PREFIX);
		send_scan({1'b0, KEY_CTRL});
		send_scan(SC_PREFIX);
		send_scan({1'b0, KEY_ALT});
		send_scan({1'b0, KEY_Q});
		send_scan(SC_PREFIX);
		send_scan({1'b1, KEY_ALT});
		send_scan(SC_PREFIX);
		send_scan({1'b1, KEY_CTRL});
		send_scan(SC_PREFIX);
		send_scan(8'h11);
		send_scan(SC_PREFIX);
		send_scan({1'b1, KEY_NAV_UP});
		send_scan(SC_PREFIX);
		send_poll();
		send_scan({1'b0, KEY_NAV_UP});
		send_scan({1'b0, KEY_ALT});
		send_scan({1'b1, KEY_ALT});
		send_scan({1'b1, KEY_Q});
	endtask

	task automatic run_random(input int item_limit);
		logic [6:0] mods [5];
		logic [6:0] ext [7];
		logic [6:0] k;
		int         sel;
		mods = '{KEY_LSHIFT, KEY_RSHIFT, KEY_CAPS, KEY_CTRL, KEY_ALT};
		ext = '{KEY_NAV_UP, KEY_NAV_DOWN, KEY_NAV_LEFT, KEY_NAV_RIGHT, KEY_NAV_HOME, KEY_CTRL,
			KEY_ALT};
		while (items_sent < item_limit) begin
			if ($urandom_range(0, 49) == 0)
				max_gap = ($urandom_range(0, 2) == 0) ? 0 : 6;
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				k = 7'($urandom);
				repeat ($urandom_range(1, 2)) send_scan({1'b0, k});
				send_scan({1'b1, k});
			end else if (sel < 50) begin
				send_scan({1'($urandom), mods[$urandom_range(0, 4)]});
			end else if (sel < 65) begin
				send_scan(SC_PREFIX);
				if ($urandom_range(0, 9) == 0)
					send_scan(SC_PREFIX);
				k = ($urandom_range(0, 4) == 0) ? 7'($urandom) : ext[$urandom_range(0, 6)];
				send_scan({1'($urandom_range(0, 9) < 3), k});
			end else if (sel < 75) begin
				send_write(2'($urandom), 2'($urandom), 7'($urandom), pick_char());
			end else if (sel < 80) begin
				send_poll();
			end else if (sel < 85) begin
				send_scan(SC_PREFIX);
				send_poll();
				send_scan({1'b0, ext[$urandom_range(0, 4)]});
			end else if (sel < 95) begin
				send_scan(8'($urandom));
			end else begin
				send_item(OP_UNUSED, 8'($urandom), 2'($urandom), 2'($urandom), 7'($urandom),
					8'($urandom));
			end
		end
	endtask

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_POLL;
		cmd_ch.scancode = '0;
		cmd_ch.table_layout = '0;
		cmd_ch.table_modifier = '0;
		cmd_ch.table_keycode = '0;
		cmd_ch.table_char = '0;
		res_ch.ready = 1'b0;
		items_sent = 0;
		max_gap = 6;
		cur_layout = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 0)
				apply_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
			else if (p == 1)
				apply_config(8'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
			else
				apply_config(8'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), pick_char());
			run_random(ITEM_TARGET * (p + 1) / PHASES);
		end
		drain();
		repeat (8) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
